### hdl/lbq_pkg.sv
package lbq_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES);
  localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(ENTRIES - 2);

  localparam int ID_W     = 16;
  localparam int SIZE_W   = 32;
  localparam int QUOTA_W  = 22;
  localparam int KB_SHIFT = 10;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_TOUCHED = 3'd1;
  localparam logic [2:0] ST_EVICTED = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;
  localparam logic [2:0] ST_MISSING = 3'd5;

  typedef struct packed {
    logic load;
    logic pop;
    logic sweep;
    logic shift_all;
    logic shift_mark;
    logic touch;
    logic append;
  } lbq_ctrl_t;

endpackage

### hdl/lbq_cell.sv
module lbq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  lbq_pkg::lbq_ctrl_t            ctrl,
  input  logic                          is_first,
  input  logic [lbq_pkg::ID_W-1:0]      cmp_id,
  input  logic [lbq_pkg::ID_W-1:0]      new_id,
  input  logic [lbq_pkg::SIZE_W-1:0]    new_size,
  input  logic                          up_valid,
  input  logic [lbq_pkg::ID_W-1:0]      up_id,
  input  logic [lbq_pkg::SIZE_W-1:0]    up_size,
  input  logic                          dn_valid,
  input  logic                          dn_mark,
  input  logic [lbq_pkg::ID_W-1:0]      dn_cid,
  input  logic [lbq_pkg::SIZE_W-1:0]    dn_csz,
  output logic                          valid,
  output logic [lbq_pkg::ID_W-1:0]      id,
  output logic [lbq_pkg::SIZE_W-1:0]    size,
  output logic                          mark,
  output logic [lbq_pkg::ID_W-1:0]      cid,
  output logic [lbq_pkg::SIZE_W-1:0]    csz
);

  logic hit;
  logic top_valid;
  logic keep_top;
  logic take_up;
  logic fill;

  always_comb begin
    hit       = valid & (ctrl.pop ? is_first : (id == cmp_id));
    top_valid = valid & ~up_valid;
    keep_top  = ctrl.touch & mark & top_valid;
    take_up   = ctrl.shift_all | (ctrl.shift_mark & mark) | (ctrl.touch & mark & ~top_valid);
    fill      = ctrl.append & ~valid & dn_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else begin
      if (take_up) begin
        valid <= up_valid;
      end else if (fill) begin
        valid <= 1'b1;
      end
      if (ctrl.load) begin
        mark <= hit;
      end else if (ctrl.sweep) begin
        mark <= mark | dn_mark;
      end
    end
  end

  // carry of the hit entry ripples one cell up per sweep cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cid <= hit ? id : '0;
      csz <= hit ? size : '0;
    end else if (ctrl.sweep) begin
      cid <= cid | dn_cid;
      csz <= csz | dn_csz;
    end
    if (take_up) begin
      id   <= up_id;
      size <= up_size;
    end else if (keep_top) begin
      id   <= cid;
      size <= csz;
    end else if (fill) begin
      id   <= new_id;
      size <= new_size;
    end
  end

endmodule

### hdl/lru_byte_quota_cache_order_top.sv
// LRU order list with a byte quota, held in a row of cells (cell 0 least recent).
// Input channel s_*: s_tuser = operation (0 push/touch, 1 pop, 2 erase, 3 dropped),
// s_tdata = item_id, item_size. Output channel m_*: m_tuser = status,
// m_tdata = entry_id, entry_size, bytes_used; m_tlast marks the final result of an item.
// cfg_we/cfg_wdata write the quota in kilobytes; write only while the block is idle.
// Timing: an item is taken only in idle. A push over quota is rejected without a sweep.
// Otherwise the hit flag and hit entry ripple up the cell row one cell per cycle
// during the sweep; then pop, erase and touch give their result. A new push then gives
// one eviction result per cycle while the receiver keeps up, then its own result.
// The next item is taken the cycle after the last result is loaded.
// Reset empties the list, clears bytes in use and the quota. When the receiver stalls
// the result stays in the output register and the sequencer waits with it.
module lru_byte_quota_cache_order_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lbq_pkg::QUOTA_W-1:0]   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,   // item_id[15:0], item_size[47:16]
  input  logic [1:0]                    s_tuser,   // operation[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [79:0]                   m_tdata,   // entry_id[15:0], entry_size[47:16],
                                                   // bytes_used[79:48]
  output logic [2:0]                    m_tuser,   // status[2:0]
  output logic                          m_tlast
);

  localparam int N = lbq_pkg::ENTRIES;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SWEEP  = 6'b000010,
    S_REMOVE = 6'b000100,
    S_TOUCH  = 6'b001000,
    S_FILL   = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [lbq_pkg::QUOTA_W-1:0] quota_kb;
  logic [lbq_pkg::SIZE_W-1:0]  quota_bytes;
  logic [1:0]                  op;
  logic [lbq_pkg::ID_W-1:0]    key_id;
  logic [lbq_pkg::SIZE_W-1:0]  key_size;
  logic [lbq_pkg::SIZE_W-1:0]  used_bytes, used_next;
  logic [lbq_pkg::CNT_W-1:0]   sweep_cnt, cnt_next;
  logic [2:0]                  rpt_status, rpt_next;

  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        too_big;
  logic                        over_quota;
  logic                        need_evict;
  logic [2:0]                  st_n;
  logic [lbq_pkg::ID_W-1:0]    eid_n;
  logic [lbq_pkg::SIZE_W-1:0]  esz_n;
  logic                        last_n;

  lbq_pkg::lbq_ctrl_t ctrl;

  logic [N-1:0]               valid_v, mark_v;
  logic [lbq_pkg::ID_W-1:0]   id_v  [N];
  logic [lbq_pkg::SIZE_W-1:0] size_v[N];
  logic [lbq_pkg::ID_W-1:0]   cid_v [N];
  logic [lbq_pkg::SIZE_W-1:0] csz_v [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                       up_valid, dn_valid, dn_mark;
    logic [lbq_pkg::ID_W-1:0]   up_id, dn_cid;
    logic [lbq_pkg::SIZE_W-1:0] up_size, dn_csz;

    if (i < N - 1) begin : g_up
      assign up_valid = valid_v[i+1];
      assign up_id    = id_v[i+1];
      assign up_size  = size_v[i+1];
    end else begin : g_up_end
      assign up_valid = 1'b0;
      assign up_id    = '0;
      assign up_size  = '0;
    end

    if (i > 0) begin : g_dn
      assign dn_valid = valid_v[i-1];
      assign dn_mark  = mark_v[i-1];
      assign dn_cid   = cid_v[i-1];
      assign dn_csz   = csz_v[i-1];
    end else begin : g_dn_end
      assign dn_valid = 1'b1;
      assign dn_mark  = 1'b0;
      assign dn_cid   = '0;
      assign dn_csz   = '0;
    end

    lbq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .is_first (i == 0),
      .cmp_id   (s_tdata[15:0]),
      .new_id   (key_id),
      .new_size (key_size),
      .up_valid (up_valid),
      .up_id    (up_id),
      .up_size  (up_size),
      .dn_valid (dn_valid),
      .dn_mark  (dn_mark),
      .dn_cid   (dn_cid),
      .dn_csz   (dn_csz),
      .valid    (valid_v[i]),
      .id       (id_v[i]),
      .size     (size_v[i]),
      .mark     (mark_v[i]),
      .cid      (cid_v[i]),
      .csz      (csz_v[i])
    );
  end

  assign s_tready    = (state == S_IDLE);
  assign in_acc      = s_tvalid & s_tready;
  assign out_free    = ~m_tvalid | m_tready;
  assign quota_bytes = {quota_kb, {lbq_pkg::KB_SHIFT{1'b0}}};
  assign too_big     = s_tdata[47:16] > quota_bytes;
  assign over_quota  = ({1'b0, used_bytes} + {1'b0, key_size}) > {1'b0, quota_bytes};
  assign need_evict  = valid_v[0] & (over_quota | valid_v[N-1]);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    out_load   = 1'b0;
    st_n       = lbq_pkg::ST_PUSHED;
    eid_n      = '0;
    esz_n      = '0;
    last_n     = 1'b1;
    used_next  = used_bytes;
    rpt_next   = rpt_status;
    cnt_next   = sweep_cnt;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          ctrl.pop  = (s_tuser == lbq_pkg::OP_POP);
          cnt_next  = '0;
          if (s_tuser == lbq_pkg::OP_PUSH) begin
            if (too_big) begin
              rpt_next   = lbq_pkg::ST_REJECT;
              state_next = S_REPORT;
            end else begin
              state_next = S_SWEEP;
            end
          end else if (s_tuser == lbq_pkg::OP_POP || s_tuser == lbq_pkg::OP_ERASE) begin
            state_next = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        ctrl.sweep = 1'b1;
        cnt_next   = sweep_cnt + 1'b1;
        if (sweep_cnt == lbq_pkg::SWEEP_LAST) begin
          state_next = (op == lbq_pkg::OP_PUSH) ? S_TOUCH : S_REMOVE;
        end
      end
      S_REMOVE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (mark_v[N-1]) begin
            ctrl.shift_mark = 1'b1;
            used_next       = used_bytes - csz_v[N-1];
            st_n            = lbq_pkg::ST_REMOVED;
            eid_n           = cid_v[N-1];
            esz_n           = csz_v[N-1];
          end else begin
            st_n = lbq_pkg::ST_MISSING;
          end
        end
      end
      S_TOUCH: begin
        if (!mark_v[N-1]) begin
          state_next = S_FILL;
        end else if (out_free) begin
          ctrl.touch = 1'b1;
          out_load   = 1'b1;
          st_n       = lbq_pkg::ST_TOUCHED;
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        if (out_free) begin
          out_load = 1'b1;
          if (need_evict) begin
            ctrl.shift_all = 1'b1;
            used_next      = used_bytes - size_v[0];
            st_n           = lbq_pkg::ST_EVICTED;
            eid_n          = id_v[0];
            esz_n          = size_v[0];
            last_n         = 1'b0;
          end else begin
            ctrl.append = 1'b1;
            used_next   = used_bytes + key_size;
            st_n        = lbq_pkg::ST_PUSHED;
            state_next  = S_IDLE;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_load   = 1'b1;
          st_n       = rpt_status;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      quota_kb   <= '0;
      used_bytes <= '0;
      sweep_cnt  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_cnt <= cnt_next;
      if (cfg_we) begin
        quota_kb <= cfg_wdata;
      end
      if (out_load) begin
        used_bytes <= used_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rpt_status <= rpt_next;
    if (in_acc) begin
      op       <= s_tuser;
      key_id   <= s_tdata[15:0];
      key_size <= s_tdata[47:16];
    end
    if (out_load) begin
      m_tuser <= st_n;
      m_tdata <= {used_next, esz_n, eid_n};
      m_tlast <= last_n;
    end
  end

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (((valid_v >> 1) & ~valid_v) == '0))
    else $error("occupied cells not contiguous from cell 0");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    !valid_v[0] |-> (used_bytes == '0))
    else $error("bytes in use with an empty list");

  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == lbq_pkg::ST_EVICTED) == !m_tlast))
    else $error("last flag disagrees with status");

  a_sweep_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && sweep_cnt != lbq_pkg::SWEEP_LAST) |=> (state == S_SWEEP))
    else $error("sweep ended early");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = lbq_pkg::ENTRIES;
  localparam int QUOTA_W = lbq_pkg::QUOTA_W;

  localparam logic [1:0] OP_PUSH  = lbq_pkg::OP_PUSH;
  localparam logic [1:0] OP_POP   = lbq_pkg::OP_POP;
  localparam logic [1:0] OP_ERASE = lbq_pkg::OP_ERASE;

  localparam logic [2:0] ST_PUSHED  = lbq_pkg::ST_PUSHED;
  localparam logic [2:0] ST_TOUCHED = lbq_pkg::ST_TOUCHED;
  localparam logic [2:0] ST_EVICTED = lbq_pkg::ST_EVICTED;
  localparam logic [2:0] ST_REMOVED = lbq_pkg::ST_REMOVED;
  localparam logic [2:0] ST_REJECT  = lbq_pkg::ST_REJECT;
  localparam logic [2:0] ST_MISSING = lbq_pkg::ST_MISSING;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = ENTRIES + 8;
  localparam int PLAN_ROWS      = 24;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 36;
  localparam logic [QUOTA_W-1:0] QUOTA_MAX = '1;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [31:0] entry_size;
    logic [31:0] bytes_used;
    logic        last;
  } cache_result_t;

  typedef struct {
    bit                 is_cfg;
    logic [QUOTA_W-1:0] quota;
    logic [1:0]         op;
    logic [15:0]        id;
    logic [31:0]        size;
    int                 rep;
    bit                 typed;
    logic [2:0]         status;
    logic [15:0]        entry_id;
    logic [31:0]        entry_size;
    logic [31:0]        bytes_used;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [QUOTA_W-1:0]  cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [47:0]         s_tdata;   // item_id[15:0], item_size[47:16]
  logic [1:0]          s_tuser;   // operation[1:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [79:0]         m_tdata;   // entry_id[15:0], entry_size[47:16], bytes_used[79:48]
  logic [2:0]          m_tuser;   // status[2:0]
  logic                m_tlast;

  lru_byte_quota_cache_order_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow of the recency list, index 0 least recent
  logic [15:0]        held_ids[ENTRIES];
  logic [31:0]        held_sizes[ENTRIES];
  int                 held_count = 0;
  logic [31:0]        held_bytes = '0;
  logic [QUOTA_W-1:0] quota_kb = '0;

  cache_result_t pending_results[$];
  plan_row_t     plan[PLAN_ROWS];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int evictions_seen = 0;
  int quota_writes = 0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_result(logic [2:0] st, logic [15:0] id, logic [31:0] sz);
    cache_result_t r;
    r.status = st;
    r.entry_id = id;
    r.entry_size = sz;
    r.bytes_used = held_bytes;
    r.last = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int find_entry(logic [15:0] id);
    for (int i = 0; i < held_count; i++)
      if (held_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i < held_count - 1; i++) begin
      held_ids[i] = held_ids[i+1];
      held_sizes[i] = held_sizes[i+1];
    end
    held_count--;
  endfunction

  function automatic void append_entry(logic [15:0] id, logic [31:0] sz);
    held_ids[held_count] = id;
    held_sizes[held_count] = sz;
    held_count++;
  endfunction

  function automatic void predict_cache(logic [1:0] op, logic [15:0] id, logic [31:0] size);
    logic [32:0] limit;
    logic [15:0] vid;
    logic [31:0] vsz;
    int pos;
    limit = {1'b0, quota_kb, 10'b0};
    case (op)
      OP_PUSH: begin
        if ({1'b0, size} > limit) begin
          note_result(ST_REJECT, '0, '0);
        end else begin
          pos = find_entry(id);
          if (pos >= 0) begin
            vid = held_ids[pos];
            vsz = held_sizes[pos];
            drop_entry(pos);
            append_entry(vid, vsz);
            note_result(ST_TOUCHED, '0, '0);
          end else begin
            while (held_count > 0 &&
                   (({1'b0, held_bytes} + {1'b0, size} > limit) || held_count >= ENTRIES)) begin
              vid = held_ids[0];
              vsz = held_sizes[0];
              drop_entry(0);
              held_bytes -= vsz;
              note_result(ST_EVICTED, vid, vsz);
            end
            append_entry(id, size);
            held_bytes += size;
            note_result(ST_PUSHED, '0, '0);
          end
        end
      end
      OP_POP, OP_ERASE: begin
        pos = (op == OP_POP) ? ((held_count > 0) ? 0 : -1) : find_entry(id);
        if (pos < 0) begin
          note_result(ST_MISSING, '0, '0);
        end else begin
          vid = held_ids[pos];
          vsz = held_sizes[pos];
          drop_entry(pos);
          held_bytes -= vsz;
          note_result(ST_REMOVED, vid, vsz);
        end
      end
      default: ;
    endcase
    if (op != OP_UNUSED)
      pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] id, logic [31:0] size);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {size, id};
    do @(posedge clk); while (!s_tready);
    predict_cache(op, id, size);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quota(logic [QUOTA_W-1:0] kb);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= kb;
    @(negedge clk);
    cfg_we <= 1'b0;
    quota_kb = kb;
    quota_writes++;
  endtask

  task automatic send_random_item(output logic [1:0] op);
    logic [15:0] id;
    logic [31:0] size;
    logic [31:0] qb;
    int roll;
    qb = {quota_kb, 10'b0};
    roll = $urandom_range(0, 99);
    if (roll < 55) op = OP_PUSH;
    else if (roll < 70) op = OP_POP;
    else if (roll < 95) op = OP_ERASE;
    else op = OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (held_count > 0 && roll < 40) id = held_ids[$urandom_range(0, held_count - 1)];
    else if (roll < 85) id = 16'($urandom_range(0, 31));
    else id = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35) size = $urandom_range(0, qb / 4);
    else if (roll < 55) size = $urandom_range(0, qb);
    else if (roll < 65) size = qb;
    else if (roll < 75) size = qb + 1;
    else if (roll < 85) size = $urandom;
    else size = $urandom_range(0, 255);
    send_item(op, id, size);
  endtask

  // receiver pacing
  initial begin : sink_pacing
    int run;
    int gap;
    m_tready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      @(negedge clk);
      m_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser == ST_EVICTED) evictions_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status 0x%0h data 0x%0h", m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("entry_id", 32'(want.entry_id), 32'(m_tdata[15:0]));
        check_field("entry_size", want.entry_size, m_tdata[47:16]);
        check_field("bytes_used", want.bytes_used, m_tdata[79:48]);
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [QUOTA_W-1:0] quota_plan[RANDOM_PHASES];
    logic [1:0] op;
    int done;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;

    //         cfg quota      op         id        size          rep typ status      eid       esize         bytes
    plan[0]  = '{0, '0,        OP_POP,   16'h0,    32'h0,         1, 1, ST_MISSING, 16'h0,    32'h0, 32'h0};
    plan[1]  = '{0, '0,        OP_ERASE, 16'h5,    32'h0,         1, 1, ST_MISSING, 16'h0,    32'h0, 32'h0};
    plan[2]  = '{0, '0,        OP_PUSH,  16'h1,    32'h1,         1, 1, ST_REJECT,  16'h0,    32'h0, 32'h0};
    plan[3]  = '{0, '0,        OP_PUSH,  16'hFFFF, 32'hFFFF_FFFF, 1, 1, ST_REJECT,  16'h0,    32'h0, 32'h0};
    plan[4]  = '{0, '0,        OP_PUSH,  16'h7,    32'h0,         1, 1, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[5]  = '{0, '0,        OP_UNUSED, 16'hAAAA, 32'h5555_5555, 1, 0, ST_PUSHED, 16'h0,    32'h0, 32'h0};
    plan[6]  = '{0, '0,        OP_POP,   16'h0,    32'h0,         1, 1, ST_REMOVED, 16'h7,    32'h0, 32'h0};
    plan[7]  = '{1, QUOTA_MAX, OP_PUSH,  16'h0,    32'h0,         0, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[8]  = '{0, '0,        OP_PUSH,  16'h0,    32'hFFFF_FC00, 1, 1, ST_PUSHED,  16'h0,    32'h0,
                 32'hFFFF_FC00};
    plan[9]  = '{0, '0,        OP_PUSH,  16'hFFFF, 32'hFFFF_FFFF, 1, 1, ST_REJECT,  16'h0,    32'h0,
                 32'hFFFF_FC00};
    // fill to capacity, then a new id overflows the table
    plan[10] = '{0, '0,        OP_PUSH,  16'h100,  32'd16,       16, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[11] = '{0, '0,        OP_PUSH,  16'h200,  32'd1,         1, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[12] = '{0, '0,        OP_PUSH,  16'h105,  32'd7,         1, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    // quota drops under bytes in use: next new id flushes the whole list
    plan[13] = '{1, '0,        OP_PUSH,  16'h0,    32'h0,         0, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[14] = '{0, '0,        OP_PUSH,  16'h300,  32'h0,         1, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[15] = '{1, 22'd4,     OP_PUSH,  16'h0,    32'h0,         0, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[16] = '{0, '0,        OP_ERASE, 16'h300,  32'h0,         1, 1, ST_REMOVED, 16'h300,  32'h0, 32'h0};
    plan[17] = '{0, '0,        OP_ERASE, 16'h1234, 32'h0,         1, 1, ST_MISSING, 16'h0,    32'h0, 32'h0};
    plan[18] = '{0, '0,        OP_POP,   16'h0,    32'h0,         1, 1, ST_MISSING, 16'h0,    32'h0, 32'h0};
    plan[19] = '{0, '0,        OP_PUSH,  16'h400,  32'd4096,      1, 1, ST_PUSHED,  16'h0,    32'h0,
                 32'd4096};
    plan[20] = '{0, '0,        OP_PUSH,  16'h401,  32'd4097,      1, 1, ST_REJECT,  16'h0,    32'h0,
                 32'd4096};
    plan[21] = '{0, '0,        OP_PUSH,  16'h402,  32'd1,         1, 0, ST_PUSHED,  16'h0,    32'h0, 32'h0};
    plan[22] = '{0, '0,        OP_PUSH,  16'h402,  32'd100,       1, 1, ST_TOUCHED, 16'h0,    32'h0, 32'd1};
    plan[23] = '{0, '0,        OP_ERASE, 16'hFFFF, 32'h0,         1, 1, ST_MISSING, 16'h0,    32'h0, 32'd1};

    quota_plan = '{22'd1, 22'd4, 22'd0, 22'd2, 22'd16, QUOTA_MAX, 22'd8, 22'd0, 22'd3, 22'd64};
    quota_plan[7] = 22'($urandom_range(1, 4194303));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_quota(plan[r].quota);
      end else begin
        for (int k = 0; k < plan[r].rep; k++) begin
          send_item(plan[r].op, plan[r].id + 16'(k), plan[r].size);
          if (plan[r].typed) begin
            pending_results[pending_results.size()-1] =
              '{plan[r].status, plan[r].entry_id, plan[r].entry_size,
                plan[r].bytes_used, 1'b1};
          end
        end
      end
    end

    foreach (quota_plan[p]) begin
      write_quota(quota_plan[p]);
      done = 0;
      while (done < PHASE_ITEMS) begin
        send_random_item(op);
        if (op != OP_UNUSED) done++;
      end
    end

    settle();
    $display("tb: %0d items sent, %0d results checked, %0d evictions, %0d quota settings",
             items_sent, results_seen, evictions_seen, quota_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
